>>> src/nva_pkg.sv
// nva_pkg: shared types, codes and helpers of the note voice allocator
// no dependencies; imported by every module under src
`timescale 1ns / 1ps

package nva_pkg;

    // default number of voice slots
    localparam int VOICE_COUNT_DEF = 16;

    // at most this many results per request
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // command codes
    localparam logic CMD_NOTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_ON   = 2'd0;
    localparam logic [1:0] KIND_OFF  = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    // velocity scale and ceiling for note-on
    localparam int VEL_SCALE = 3;
    localparam int VEL_MAX   = 127;

    typedef struct packed {
        logic       command;
        logic [3:0] channel;
        logic [6:0] note;
        logic [5:0] velocity;
        logic [5:0] duration;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] out_channel;
        logic [6:0] out_note;
        logic [6:0] out_velocity;
        logic [3:0] voice_index;
        logic       last;
    } t_out_item;

    // one voice slot as stored in the voice table
    typedef struct packed {
        logic [3:0] channel;
        logic [6:0] note;
        logic [5:0] level;
        logic [5:0] remaining;
    } t_voice;

    // write request into the voice table (address travels separately)
    typedef struct packed {
        logic   en;
        t_voice data;
    } t_voice_wr;

    // sequencer to result stage
    typedef struct packed {
        logic      push;
        logic      flush;
        t_out_item item;
    } t_emit_req;

    // velocity times three, saturated at 127
    function automatic logic [6:0] scale_vel(input logic [5:0] vel);
        logic [7:0] prod;
        prod = 8'(vel) * 8'(VEL_SCALE);
        if (prod > 8'(VEL_MAX)) begin
            return 7'(VEL_MAX);
        end
        return prod[6:0];
    endfunction

endpackage

>>> src/note_voice_allocator.sv
// note_voice_allocator: top level of the note voice allocator
// depends on nva_pkg, nva_store, nva_ctrl, nva_emit
`timescale 1ns / 1ps

// channel   | direction | handshake                 | payload
// request   | in        | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
// result    | out       | o_out_valid / i_out_stall | o_out_item (t_out_item)
//
// one request at a time; the voice slots take turns on the shared unit
// tick: a scan of every slot, a none result if no voice ends, then a flush
// note: a release scan of every slot, then a search from slot zero that places the
//   note in the first free slot, or a none result when all are busy, then a flush
// the next request is taken in the idle state; a stalled output holds the scan
//   at a pending result
// reset is synchronous; valid bits make all voices read free, no clearing pass
// the next request is taken while the last result still waits at the output

module note_voice_allocator import nva_pkg::*; #(
    parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // slot index width, at least one bit
    localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    // voice table ports
    logic [IDX_W-1:0] rd_addr;
    t_voice           rd_data;
    logic             rd_vld;
    logic [IDX_W-1:0] wr_addr;
    t_voice_wr        wr;

    // sequencer to result stage
    t_emit_req        emit_req;
    logic             emit_rdy;

    // voice table: channel, note, level and ticks left per slot
    nva_store #(
        .VOICE_COUNT (VOICE_COUNT),
        .IDX_W       (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_rd_vld  (rd_vld),
        .i_wr_addr (wr_addr),
        .i_wr      (wr)
    );

    // walks the slots once per pass: release / countdown, then for a note a free-slot search
    nva_ctrl #(
        .VOICE_COUNT (VOICE_COUNT),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .i_rd_vld   (rd_vld),
        .o_wr_addr  (wr_addr),
        .o_wr       (wr),
        .o_emit     (emit_req),
        .i_emit_rdy (emit_rdy)
    );

    // holds the newest result until the next one or the end of the request
    // decides its last flag
    nva_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (emit_req),
        .o_rdy       (emit_rdy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

>>> src/nva_store.sv
// nva_store: voice table memory with registered read and per-slot valid bits
// depends on nva_pkg
`timescale 1ns / 1ps

module nva_store import nva_pkg::*; #(
    parameter int VOICE_COUNT = VOICE_COUNT_DEF,
    parameter int IDX_W       = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_voice           o_rd_data,
    output logic             o_rd_vld,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_voice_wr        i_wr
);

    t_voice                 r_mem [VOICE_COUNT];
    t_voice                 r_rd_data;
    logic [VOICE_COUNT-1:0] r_vld;
    logic                   r_rd_vld;
    logic                   wr_hit;

    // write-first when both ports hit the same slot
    assign wr_hit = i_wr.en && (i_wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
        r_rd_data <= wr_hit ? i_wr.data : r_mem[i_rd_addr];
    end

    // slots never written read as free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= wr_hit ? 1'b1 : r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_vld  = r_rd_vld;

endmodule

>>> src/nva_emit.sv
// nva_emit: result stage, one hold slot that learns the last flag plus output register
// depends on nva_pkg
`timescale 1ns / 1ps

module nva_emit import nva_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_emit_req i_req,
    output logic      o_rdy,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_hold_vld, n_hold_vld;
    t_out_item r_hold, n_hold;
    logic      r_out_vld, n_out_vld;
    t_out_item r_out, n_out;
    logic      out_free;
    logic      load_out;

    assign out_free = !r_out_vld || !i_out_stall;
    assign o_rdy    = !r_hold_vld || out_free;

    always_comb begin
        n_hold_vld = r_hold_vld;
        n_hold     = r_hold;
        n_out      = r_out;
        load_out   = 1'b0;
        if (i_req.push && o_rdy) begin
            // a newer result exists, so the held one is not last
            if (r_hold_vld) begin
                load_out   = 1'b1;
                n_out      = r_hold;
                n_out.last = 1'b0;
            end
            n_hold     = i_req.item;
            n_hold_vld = 1'b1;
        end else if (i_req.flush && r_hold_vld && out_free) begin
            load_out   = 1'b1;
            n_out      = r_hold;
            n_out.last = 1'b1;
            n_hold_vld = 1'b0;
        end
        n_out_vld = out_free ? load_out : r_out_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    a_no_push_and_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.push && i_req.flush))
        else $error("push and flush in the same cycle");

    a_flush_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.flush |-> r_hold_vld)
        else $error("flush with no held result");

    a_push_moves_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.push && o_rdy && r_hold_vld) |=> (r_out_vld && !r_out.last && r_hold_vld))
        else $error("held result not moved to output on push");

endmodule

>>> src/nva_ctrl.sv
// nva_ctrl: request sequencer with the shared compare / countdown unit
// depends on nva_pkg; drives nva_store and nva_emit
`timescale 1ns / 1ps

module nva_ctrl import nva_pkg::*; #(
    parameter int VOICE_COUNT = VOICE_COUNT_DEF,
    parameter int IDX_W       = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic [IDX_W-1:0] o_rd_addr,
    input  t_voice           i_rd_data,
    input  logic             i_rd_vld,
    output logic [IDX_W-1:0] o_wr_addr,
    output t_voice_wr        o_wr,
    output t_emit_req        o_emit,
    input  logic             i_emit_rdy
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PLACE,
        S_NONE,
        S_FLUSH
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_in_item         r_cmd, n_cmd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [5:0] rem;
    logic       busy;
    logic       hit;
    logic       wr_need;
    logic       push_want;
    logic       cnt_ok;
    logic       is_tick;

    // shared unit: slot state, match compare and countdown
    assign rem     = i_rd_vld ? i_rd_data.remaining : 6'd0;
    assign busy    = (rem != 6'd0);
    assign cnt_ok  = (r_cnt < CNT_W'(MAX_RESULTS));
    assign is_tick = (r_cmd.command == CMD_TICK);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cmd     = r_cmd;
        n_cnt     = r_cnt;
        hit       = 1'b0;
        wr_need   = 1'b0;
        push_want = 1'b0;
        o_wr      = '0;
        o_wr.data = i_rd_data;
        o_emit    = '0;
        o_emit.item.voice_index = 4'(r_idx);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_item;
                    n_cnt   = '0;
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_emit.item.kind = KIND_OFF;
                if (is_tick) begin
                    // count down, release at zero
                    hit                     = busy && (rem == 6'd1);
                    wr_need                 = busy;
                    o_wr.data.remaining     = rem - 6'd1;
                    o_emit.item.out_channel = i_rd_data.channel;
                    o_emit.item.out_note    = i_rd_data.note;
                end else begin
                    // retrigger: free the sounding copy of this note
                    hit = busy && (i_rd_data.channel == r_cmd.channel)
                               && (i_rd_data.note == r_cmd.note);
                    wr_need                 = hit;
                    o_wr.data.remaining     = 6'd0;
                    o_emit.item.out_channel = r_cmd.channel;
                    o_emit.item.out_note    = r_cmd.note;
                end
                push_want = hit && cnt_ok;
                if (!push_want || i_emit_rdy) begin
                    o_wr.en     = wr_need;
                    o_emit.push = push_want;
                    if (push_want) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    if (r_idx == LAST_IDX) begin
                        n_idx = '0;
                        if (!is_tick) begin
                            n_state = S_PLACE;
                        end else if (n_cnt == '0) begin
                            n_state = S_NONE;
                        end else begin
                            n_state = S_FLUSH;
                        end
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_PLACE: begin
                o_emit.item.kind         = KIND_ON;
                o_emit.item.out_channel  = r_cmd.channel;
                o_emit.item.out_note     = r_cmd.note;
                o_emit.item.out_velocity = scale_vel(r_cmd.velocity);
                o_wr.data.channel        = r_cmd.channel;
                o_wr.data.note           = r_cmd.note;
                o_wr.data.level          = r_cmd.velocity;
                o_wr.data.remaining      = r_cmd.duration;
                if (!busy) begin
                    push_want = cnt_ok;
                    if (!push_want || i_emit_rdy) begin
                        o_wr.en     = 1'b1;
                        o_emit.push = push_want;
                        if (push_want) begin
                            n_cnt = r_cnt + CNT_W'(1);
                        end
                        n_idx   = '0;
                        n_state = S_FLUSH;
                    end
                end else if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_NONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_NONE: begin
                o_emit.item.kind        = KIND_NONE;
                o_emit.item.voice_index = 4'd0;
                if (!is_tick) begin
                    o_emit.item.out_channel = r_cmd.channel;
                    o_emit.item.out_note    = r_cmd.note;
                end
                push_want = cnt_ok;
                if (!push_want || i_emit_rdy) begin
                    o_emit.push = push_want;
                    if (push_want) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_emit.flush = 1'b1;
                if (i_emit_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
        end
        r_cmd <= n_cmd;
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_rd_addr  = n_idx;
    assign o_wr_addr  = r_idx;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("result count above limit");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_SCAN && r_idx == '0))
        else $error("request did not start a scan at slot zero");

    a_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |-> (r_state == S_SCAN || r_state == S_PLACE))
        else $error("voice table written outside a scan");

    a_place_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLACE && o_wr.en) |=> (r_state == S_FLUSH))
        else $error("placement did not end the request");

endmodule

>>> bench/note_voice_allocator_tb.sv
// note_voice_allocator_tb: self-checking bench for the note voice allocator
// depends on nva_pkg and note_voice_allocator; checks against a shadow voice table
`timescale 1ns / 1ps

module note_voice_allocator_tb import nva_pkg::*;;

    localparam int VOICES      = VOICE_COUNT_DEF;
    localparam int PHASE_ITEMS = 100;
    localparam int BURST_NOTES = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG    = 3000;
    localparam int TAIL_CYCLES = 2 * VOICES + 8;

    typedef struct {
        t_in_item  rq;
        bit        typed;
        t_out_item want;
    } t_opening_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // shadow copy of the voice table
    logic [3:0] shadow_chan  [VOICES];
    logic [6:0] shadow_note  [VOICES];
    logic [5:0] shadow_level [VOICES];
    logic [5:0] shadow_left  [VOICES] = '{default: '0};

    t_out_item    step_events [MAX_RESULTS];
    int           step_count;
    t_out_item    pending_events[$];
    t_opening_row opening_rows[$];

    int mismatch_count = 0;
    int in_idle_pct    = 0;
    int out_idle_pct   = 0;
    int hold_asks      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    note_voice_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_in_item mk_req(logic cmd, logic [3:0] ch, logic [6:0] nt,
                                        logic [5:0] vel, logic [5:0] dur);
        t_in_item rq;
        rq.command  = cmd;
        rq.channel  = ch;
        rq.note     = nt;
        rq.velocity = vel;
        rq.duration = dur;
        return rq;
    endfunction

    function automatic t_out_item mk_event(logic [1:0] kind, logic [3:0] ch, logic [6:0] nt,
                                           logic [6:0] vel, logic [3:0] slot, logic lst);
        t_out_item ev;
        ev.kind         = kind;
        ev.out_channel  = ch;
        ev.out_note     = nt;
        ev.out_velocity = vel;
        ev.voice_index  = slot;
        ev.last         = lst;
        return ev;
    endfunction

    function automatic void add_event(logic [1:0] kind, logic [3:0] ch, logic [6:0] nt,
                                      logic [6:0] vel, logic [3:0] slot);
        // anything past the result cap is dropped, the voice is still freed
        if (step_count < MAX_RESULTS) begin
            step_events[step_count] = mk_event(kind, ch, nt, vel, slot, 1'b0);
            step_count++;
        end
    endfunction

    // applies one request to the shadow table and lists the messages it causes
    function automatic void allocate_voices(input t_in_item rq);
        int v;
        int loud;
        bit placed;
        step_count = 0;
        placed     = 1'b0;
        if (rq.command == CMD_TICK) begin
            for (v = 0; v < VOICES; v++) begin
                if (shadow_left[v] != 0) begin
                    shadow_left[v] = shadow_left[v] - 6'd1;
                    if (shadow_left[v] == 0) begin
                        add_event(KIND_OFF, shadow_chan[v], shadow_note[v], 7'd0, 4'(v));
                    end
                end
            end
            // idle tick still answers once
            if (step_count == 0) begin
                add_event(KIND_NONE, 4'd0, 7'd0, 7'd0, 4'd0);
            end
        end else begin
            // a sounding voice with the same channel and note is cut first
            for (v = 0; v < VOICES; v++) begin
                if (shadow_left[v] != 0 && shadow_chan[v] == rq.channel &&
                    shadow_note[v] == rq.note) begin
                    add_event(KIND_OFF, rq.channel, rq.note, 7'd0, 4'(v));
                    shadow_left[v] = '0;
                end
            end
            // lowest free voice takes the note; zero length leaves it free
            for (v = 0; v < VOICES && !placed; v++) begin
                if (shadow_left[v] == 0) begin
                    loud = int'(rq.velocity) * VEL_SCALE;
                    if (loud > VEL_MAX) begin
                        loud = VEL_MAX;
                    end
                    shadow_chan[v]  = rq.channel;
                    shadow_note[v]  = rq.note;
                    shadow_level[v] = rq.velocity;
                    shadow_left[v]  = rq.duration;
                    add_event(KIND_ON, rq.channel, rq.note, 7'(loud), 4'(v));
                    placed = 1'b1;
                end
            end
            if (!placed) begin
                add_event(KIND_NONE, rq.channel, rq.note, 7'd0, 4'd0);
            end
        end
        step_events[step_count - 1].last = 1'b1;
    endfunction

    // mostly a small pool of channels and notes so that repeats hit sounding voices
    function automatic t_in_item random_request(input bit held);
        t_in_item rq;
        rq.command = (!held && $urandom_range(0, 99) < 30) ? CMD_TICK : CMD_NOTE;
        if ($urandom_range(0, 3) == 0) begin
            rq.channel = 4'($urandom_range(0, 15));
            rq.note    = 7'($urandom_range(0, 127));
        end else begin
            rq.channel = 4'($urandom_range(0, 3));
            rq.note    = 7'(60 + $urandom_range(0, 7));
        end
        rq.velocity = 6'($urandom_range(0, 63));
        if (held) begin
            rq.duration = 6'($urandom_range(3, 12));
        end else if ($urandom_range(0, 7) == 0) begin
            rq.duration = 6'($urandom_range(0, 63));
        end else begin
            rq.duration = 6'($urandom_range(0, 6));
        end
        return rq;
    endfunction

    task automatic offer_request(input t_in_item rq, input bit typed, input t_out_item want);
        int gap;
        int k;
        gap = 0;
        while ($urandom_range(0, 99) < in_idle_pct && gap < 20) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= rq;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        allocate_voices(rq);
        if (typed) begin
            pending_events.push_back(want);
        end else begin
            for (k = 0; k < step_count; k++) begin
                pending_events.push_back(step_events[k]);
            end
        end
    endtask

    // sender pauses until every expected message has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_events.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_event(input t_out_item got);
        t_out_item want;
        if (pending_events.size() == 0) begin
            $error("unexpected result: kind %0d channel %0d note %0d voice %0d",
                   got.kind, got.out_channel, got.out_note, got.voice_index);
            mismatch_count++;
        end else begin
            want = pending_events.pop_front();
            compare_field("kind", int'(want.kind), int'(got.kind));
            compare_field("out_channel", int'(want.out_channel), int'(got.out_channel));
            compare_field("out_note", int'(want.out_note), int'(got.out_note));
            compare_field("out_velocity", int'(want.out_velocity), int'(got.out_velocity));
            compare_field("voice_index", int'(want.voice_index), int'(got.voice_index));
            compare_field("last", int'(want.last), int'(got.last));
        end
    endtask

    // result side: check, then choose the stall for the next cycle
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
                check_event(o_out_item);
            end
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < out_idle_pct);
            end
        end
    end

    // ends the run when no request and no result moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int k;
        int phase;
        int sent;

        // opening table: typed rows are plain to read, the rest predicted
        opening_rows.push_back('{mk_req(CMD_TICK, 4'd0, 7'd0, 6'd0, 6'd0), 1'b1,
                                 mk_event(KIND_NONE, 4'd0, 7'd0, 7'd0, 4'd0, 1'b1)});
        opening_rows.push_back('{mk_req(CMD_NOTE, 4'd0, 7'd0, 6'd0, 6'd1), 1'b1,
                                 mk_event(KIND_ON, 4'd0, 7'd0, 7'd0, 4'd0, 1'b1)});
        opening_rows.push_back('{mk_req(CMD_NOTE, 4'd15, 7'd127, 6'd63, 6'd63), 1'b1,
                                 mk_event(KIND_ON, 4'd15, 7'd127, 7'd127, 4'd1, 1'b1)});
        // zero length: sounds but the voice stays free
        opening_rows.push_back('{mk_req(CMD_NOTE, 4'd3, 7'd60, 6'd42, 6'd0), 1'b1,
                                 mk_event(KIND_ON, 4'd3, 7'd60, 7'd126, 4'd2, 1'b1)});
        // same note again: no note-off, velocity just past the ceiling
        opening_rows.push_back('{mk_req(CMD_NOTE, 4'd3, 7'd60, 6'd43, 6'd5), 1'b1,
                                 mk_event(KIND_ON, 4'd3, 7'd60, 7'd127, 4'd2, 1'b1)});
        opening_rows.push_back('{mk_req(CMD_TICK, 4'd15, 7'd127, 6'd63, 6'd63), 1'b1,
                                 mk_event(KIND_OFF, 4'd0, 7'd0, 7'd0, 4'd0, 1'b1)});
        // retrigger of a sounding note
        opening_rows.push_back('{mk_req(CMD_NOTE, 4'd15, 7'd127, 6'd1, 6'd2), 1'b0, '0});
        // fill every remaining voice with one-tick notes
        for (k = 0; k < VOICES - 2; k++) begin
            opening_rows.push_back('{mk_req(CMD_NOTE, 4'(k), 7'(100 + k), 6'(4 * k), 6'd1),
                                     1'b0, '0});
        end
        // table full
        opening_rows.push_back('{mk_req(CMD_NOTE, 4'd9, 7'd9, 6'd20, 6'd3), 1'b1,
                                 mk_event(KIND_NONE, 4'd9, 7'd9, 7'd0, 4'd0, 1'b1)});
        // many voices expire on one tick
        opening_rows.push_back('{mk_req(CMD_TICK, 4'd0, 7'd0, 6'd0, 6'd0), 1'b0, '0});

        in_idle_pct  = 37;
        out_idle_pct = 55;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_rows[r]) begin
            offer_request(opening_rows[r].rq, opening_rows[r].typed, opening_rows[r].want);
        end
        drain_results();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    in_idle_pct  = 37;
                    out_idle_pct = 55;
                end
                1: begin
                    in_idle_pct  = 55;
                    out_idle_pct = 37;
                    // long receiver hold while requests keep coming
                    hold_asks++;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    // burst of held notes runs the table out of voices
                    repeat (BURST_NOTES) offer_request(random_request(1'b1), 1'b0, '0);
                    sent += BURST_NOTES;
                end else begin
                    offer_request(random_request(1'b0), 1'b0, '0);
                    sent++;
                end
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> files.f
src/nva_pkg.sv
src/nva_store.sv
src/nva_emit.sv
src/nva_ctrl.sv
src/note_voice_allocator.sv
bench/note_voice_allocator_tb.sv
